// ----- hw/rtl/pidc_pkg.sv -----
package pidc_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned GainW   = 16;
  localparam int unsigned ErrW    = SampleW + 1;
  localparam int unsigned DiffW   = SampleW + 2;
  localparam int unsigned SumW    = 32;
  localparam int unsigned DriveW  = 32;
  localparam int unsigned MulAW   = 17;
  localparam int unsigned MulBW   = 36;
  localparam int unsigned AccW    = 52;
  localparam int unsigned FracW   = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_PROP_GAIN   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INTEG_GAIN  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DERIV_GAIN  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_RATE = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATE,
    ST_DERIV,
    ST_INTEG,
    ST_PROP,
    ST_SUM,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MUL_RATE,
    MUL_DERIV,
    MUL_INTEG,
    MUL_PROP
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     prod_en;
    mul_sel_e mul_sel;
    logic     acc_clr;
    logic     acc_add;
    logic     out_load;
  } dp_cmd_t;

endpackage

// ----- hw/rtl/pidc_ctrl.sv -----
module pidc_ctrl import pidc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_RATE;
      ST_RATE:  state_d = ST_DERIV;
      ST_DERIV: state_d = ST_INTEG;
      ST_INTEG: state_d = ST_PROP;
      ST_PROP:  state_d = ST_SUM;
      ST_SUM:   state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_RATE: begin
        cmd_o.mul_sel = MUL_RATE;
        cmd_o.prod_en = 1'b1;
      end
      ST_DERIV: begin
        cmd_o.mul_sel = MUL_DERIV;
        cmd_o.prod_en = 1'b1;
        cmd_o.acc_clr = 1'b1;
      end
      ST_INTEG: begin
        cmd_o.mul_sel = MUL_INTEG;
        cmd_o.prod_en = 1'b1;
        cmd_o.acc_add = 1'b1;
      end
      ST_PROP: begin
        cmd_o.mul_sel = MUL_PROP;
        cmd_o.prod_en = 1'b1;
        cmd_o.acc_add = 1'b1;
      end
      ST_SUM: begin
        cmd_o.acc_add = 1'b1;
      end
      ST_DONE: begin
        cmd_o.out_load = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/pidc_datapath.sv -----
module pidc_datapath import pidc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dp_cmd_t                   cmd_i,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [GainW-1:0]          cfg_wdata_i,
  input  logic signed [SampleW-1:0] setpoint_i,
  input  logic signed [SampleW-1:0] measured_i,
  output logic signed [DriveW-1:0]  drive_o
);

  localparam int unsigned ShW = AccW - FracW;

  logic signed [GainW-1:0]   kp_q, ki_q, kd_q;
  logic        [GainW-1:0]   rate_q;
  logic signed [SumW-1:0]    err_sum_q, err_sum_d;
  logic signed [ErrW-1:0]    last_err_q;
  logic signed [DiffW-1:0]   diff_q;
  logic signed [AccW-1:0]    prod_q, acc_q;
  logic signed [DriveW-1:0]  drive_q, drive_d;

  logic signed [ErrW-1:0]    err;
  logic signed [DiffW-1:0]   diff;
  logic signed [SumW:0]      sum_wide;
  logic signed [MulAW-1:0]   mul_a;
  logic signed [MulBW-1:0]   mul_b;
  logic signed [MulAW+MulBW-1:0] mul_p;
  logic signed [ShW-1:0]     shifted;

  // error, saturating integral and error difference
  assign err      = ErrW'(setpoint_i) - ErrW'(measured_i);
  assign diff     = DiffW'(err) - DiffW'(last_err_q);
  assign sum_wide = (SumW+1)'(err_sum_q) + (SumW+1)'(err);

  always_comb begin
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      err_sum_d = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      err_sum_d = sum_wide[SumW-1:0];
    end
  end

  // shared multiplier
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_RATE: begin
        mul_a = {1'b0, rate_q};
        mul_b = MulBW'(diff_q);
      end
      MUL_DERIV: begin
        mul_a = MulAW'(kd_q);
        mul_b = prod_q[MulBW-1:0];
      end
      MUL_INTEG: begin
        mul_a = MulAW'(ki_q);
        mul_b = MulBW'(err_sum_q);
      end
      MUL_PROP: begin
        mul_a = MulAW'(kp_q);
        mul_b = MulBW'(last_err_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // floor shift and output saturation
  assign shifted = acc_q[AccW-1:FracW];

  always_comb begin
    if ((&shifted[ShW-1:DriveW-1]) || !(|shifted[ShW-1:DriveW-1])) begin
      drive_d = shifted[DriveW-1:0];
    end else if (shifted[ShW-1]) begin
      drive_d = {1'b1, {(DriveW-1){1'b0}}};
    end else begin
      drive_d = {1'b0, {(DriveW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q       <= '0;
      ki_q       <= '0;
      kd_q       <= '0;
      rate_q     <= GainW'(1);
      err_sum_q  <= '0;
      last_err_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PROP_GAIN:   kp_q   <= cfg_wdata_i;
          CFG_INTEG_GAIN:  ki_q   <= cfg_wdata_i;
          CFG_DERIV_GAIN:  kd_q   <= cfg_wdata_i;
          CFG_SAMPLE_RATE: rate_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        err_sum_q  <= err_sum_d;
        last_err_q <= err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      diff_q <= diff;
    end
    if (cmd_i.prod_en) begin
      prod_q <= mul_p[AccW-1:0];
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + prod_q;
    end
    if (cmd_i.out_load) begin
      drive_q <= drive_d;
    end
  end

  assign drive_o = drive_q;

endmodule

// ----- hw/rtl/pid_controller_step.sv -----
// Fixed-point PID step. Each request (setpoint, measured) updates a saturating
// 32-bit error integral and the stored previous error, and yields one drive
// value (Kp*e + Ki*I + Kd*rate*(e - e_prev)) >> 8 with floor rounding, clamped
// to signed 32 bits. Gains are signed Q8.8; sample_rate is unsigned. A request
// passes through the rate, derivative, integral, proportional, sum and done
// states: the single shared 17x36 multiplier forms rate*de, then the
// derivative, integral and proportional products one per cycle; the sum state
// adds the last product and the done state saturates into the result register.
// A new request is taken only once the block is back in its idle state.
// The result register lets the next request be taken while a drive value is
// still waiting; that request then holds in its saturate step until the
// waiting drive value is taken. Write configuration registers only while the
// block is idle.
module pid_controller_step import pidc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [SampleW-1:0] setpoint_i,
  input  logic signed [SampleW-1:0] measured_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [DriveW-1:0]  drive_o,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [GainW-1:0]          cfg_wdata_i
);

  dp_cmd_t cmd;

  pidc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  pidc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .setpoint_i  (setpoint_i),
    .measured_i  (measured_i),
    .drive_o     (drive_o)
  );

endmodule

// ----- hw/rtl/pidc_checker.sv -----
module pidc_checker import pidc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [DriveW-1:0] drive_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_o))
    else $error("stalled drive changed");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##1 !in_ready_o ##1 !in_ready_o)
    else $error("request taken while busy");

  a_ready_falls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i))
    else $error("ready dropped without a request");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result shown while not idle");

endmodule

bind pid_controller_step pidc_checker u_pidc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .drive_o     (drive_o)
);

// ----- dv/pid_drive_checker.sv -----
module pid_drive_checker import pidc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  input  logic                      req_ready_i,
  input  logic signed [SampleW-1:0] setpoint_i,
  input  logic signed [SampleW-1:0] measured_i,
  input  logic                      rsp_valid_i,
  input  logic                      rsp_ready_i,
  input  logic signed [DriveW-1:0]  drive_i,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [GainW-1:0]          cfg_wdata_i,
  output int unsigned               mismatches_o,
  output int unsigned               pending_o,
  output int unsigned               checked_o,
  output int unsigned               integ_clamps_o,
  output int unsigned               drive_clamps_o
);

  localparam longint S32Max = 64'sd2147483647;
  localparam longint S32Min = -64'sd2147483648;

  logic signed [GainW-1:0]  kp;
  logic signed [GainW-1:0]  ki;
  logic signed [GainW-1:0]  kd;
  logic [GainW-1:0]         rate;
  logic signed [SumW-1:0]   integ;
  logic signed [ErrW-1:0]   prev_err;
  logic signed [DriveW-1:0] drive_q[$];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches_o++;
  endtask

  function automatic longint clamp_s32(input longint x);
    if (x > S32Max) return S32Max;
    if (x < S32Min) return S32Min;
    return x;
  endfunction

  // Advances the integral and previous error, returns the expected drive.
  task automatic predict_drive(input logic signed [SampleW-1:0] sp,
                               input logic signed [SampleW-1:0] ms,
                               output logic signed [DriveW-1:0] drive);
    longint err;
    longint sum;
    longint diff;
    longint acc;
    err = longint'(sp) - longint'(ms);
    sum = longint'(integ) + err;
    if (clamp_s32(sum) != sum) integ_clamps_o++;
    sum = clamp_s32(sum);
    integ = sum[SumW-1:0];
    diff = err - longint'(prev_err);
    acc = longint'(kp) * err + longint'(ki) * sum
        + longint'(kd) * (longint'(rate) * diff);
    acc = acc >>> FracW;
    if (clamp_s32(acc) != acc) drive_clamps_o++;
    acc = clamp_s32(acc);
    drive = acc[DriveW-1:0];
    prev_err = err[ErrW-1:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [DriveW-1:0] want;
    if (!rst_ni) begin
      kp = '0;
      ki = '0;
      kd = '0;
      rate = 16'd1;
      integ = '0;
      prev_err = '0;
      drive_q.delete();
      mismatches_o = 0;
      pending_o = 0;
      checked_o = 0;
      integ_clamps_o = 0;
      drive_clamps_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PROP_GAIN:   kp = cfg_wdata_i;
          CFG_INTEG_GAIN:  ki = cfg_wdata_i;
          CFG_DERIV_GAIN:  kd = cfg_wdata_i;
          CFG_SAMPLE_RATE: rate = cfg_wdata_i;
          default: ;
        endcase
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (drive_q.size() == 0) begin
          report_mismatch($sformatf("drive %h with no request outstanding", drive_i));
        end else begin
          want = drive_q.pop_front();
          checked_o++;
          if (drive_i !== want)
            report_mismatch($sformatf("drive got %h expected %h", drive_i, want));
        end
      end
      if (req_valid_i && req_ready_i) begin
        predict_drive(setpoint_i, measured_i, want);
        drive_q.push_back(want);
      end
      pending_o = drive_q.size();
    end
  end

endmodule

// ----- dv/testbench.sv -----
module testbench;
  import pidc_pkg::*;

  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned LongHold     = 200;
  localparam int unsigned LatencyPad   = 12;
  localparam int unsigned Phases       = 8;
  localparam int unsigned PhaseItems   = 230;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [SampleW-1:0] setpoint_i;
  logic signed [SampleW-1:0] measured_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [DriveW-1:0]  drive_o;
  logic                      cfg_we_i;
  logic [CfgIdxW-1:0]        cfg_index_i;
  logic [GainW-1:0]          cfg_wdata_i;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned integ_clamps;
  int unsigned drive_clamps;
  int unsigned n_sent;
  int unsigned n_settings;

  logic tx_idle;
  logic rx_idle;
  logic long_hold;
  logic [SampleW-1:0] last_sp;
  logic [SampleW-1:0] last_ms;

  pid_controller_step DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .setpoint_i (setpoint_i),
    .measured_i (measured_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .drive_o    (drive_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  pid_drive_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (in_valid_i),
    .req_ready_i   (in_ready_o),
    .setpoint_i    (setpoint_i),
    .measured_i    (measured_i),
    .rsp_valid_i   (out_valid_o),
    .rsp_ready_i   (out_ready_i),
    .drive_i       (drive_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .checked_o     (checked),
    .integ_clamps_o(integ_clamps),
    .drive_clamps_o(drive_clamps)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= StallLimit) begin
        $display("Watchdog: no request or drive moved for %0d cycles", StallLimit);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : receiver
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (LongHold - 1) @(negedge clk_i);
        long_hold = 1'b0;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic [SampleW-1:0] sp, input logic [SampleW-1:0] ms);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    setpoint_i <= sp;
    measured_i <= ms;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_sent++;
    last_sp = sp;
    last_ms = ms;
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (LatencyPad) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [GainW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
  endtask

  task automatic program_gains(input logic [GainW-1:0] kp, input logic [GainW-1:0] ki,
                               input logic [GainW-1:0] kd, input logic [GainW-1:0] rate);
    drain_results();
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_INTEG_GAIN, ki);
    write_reg(CFG_DERIV_GAIN, kd);
    write_reg(CFG_SAMPLE_RATE, rate);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [GainW-1:0] pick_gain();
    logic [GainW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = 16'h8000;
      1: v = 16'h7FFF;
      2: v = '0;
      3: begin
        v = GainW'($urandom_range(0, 1023));
        v = v - 16'd512;
      end
      default: v = GainW'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [GainW-1:0] pick_rate();
    logic [GainW-1:0] v;
    case ($urandom_range(0, 4))
      0: v = 16'd1;
      1: v = 16'hFFFF;
      2: v = GainW'($urandom_range(2, 16));
      default: v = GainW'($urandom_range(1, 65535));
    endcase
    return v;
  endfunction

  function automatic logic [SampleW-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  task automatic pick_sample(output logic [SampleW-1:0] sp, output logic [SampleW-1:0] ms);
    logic [SampleW-1:0] delta;
    case ($urandom_range(0, 7))
      4, 5: begin
        sp = SampleW'($urandom);
        delta = SampleW'($urandom_range(0, 128));
        ms = sp + delta - 16'd64;
      end
      6: begin
        sp = pick_extreme();
        ms = pick_extreme();
      end
      7: begin
        sp = last_sp;
        ms = last_ms;
      end
      default: begin
        sp = SampleW'($urandom);
        ms = SampleW'($urandom);
      end
    endcase
  endtask

  task automatic directed_sample(input int k, output logic [SampleW-1:0] sp,
                                 output logic [SampleW-1:0] ms);
    case (k)
      0:  begin sp = 16'h0000; ms = 16'h0000; end
      1:  begin sp = 16'h7FFF; ms = 16'h8000; end
      2:  begin sp = 16'h7FFF; ms = 16'h8000; end
      3:  begin sp = 16'h8000; ms = 16'h7FFF; end
      4:  begin sp = 16'h8000; ms = 16'h7FFF; end
      5:  begin sp = 16'h0000; ms = 16'h0000; end
      6:  begin sp = 16'hFFFF; ms = 16'h0000; end
      7:  begin sp = 16'h0000; ms = 16'hFFFF; end
      8:  begin sp = 16'h0001; ms = 16'h0001; end
      9:  begin sp = 16'h8000; ms = 16'h8000; end
      10: begin sp = 16'h7FFF; ms = 16'h7FFF; end
      11: begin sp = 16'h5555; ms = 16'hAAAA; end
      12: begin sp = 16'hAAAA; ms = 16'h5555; end
      13: begin sp = 16'h8000; ms = 16'h0000; end
      14: begin sp = 16'h7FFF; ms = 16'h0000; end
      15: begin sp = 16'h0000; ms = 16'h7FFF; end
      default: begin sp = 16'h0000; ms = 16'h8000; end
    endcase
  endtask

  initial begin : stimulus
    logic [SampleW-1:0] sp;
    logic [SampleW-1:0] ms;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    setpoint_i = '0;
    measured_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_PROP_GAIN;
    cfg_wdata_i = '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    long_hold = 1'b0;
    last_sp = '0;
    last_ms = '0;
    n_sent = 0;
    n_settings = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset gains: drive stays zero while the integral and previous error move
    send_sample(16'd100, 16'hFF9C);
    send_sample(16'hFFFB, 16'd7);

    program_gains(16'h0100, 16'h0010, 16'h8000, 16'hFFFF);
    for (int k = 0; k < 17; k++) begin
      directed_sample(k, sp, ms);
      send_sample(sp, ms);
    end

    // zero sample rate kills the derivative term
    program_gains(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000);
    for (int k = 0; k < 6; k++) begin
      directed_sample(k, sp, ms);
      send_sample(sp, ms);
    end

    for (int ph = 0; ph < Phases; ph++) begin
      tx_idle = (ph < Phases - 1);
      rx_idle = (ph < Phases - 1);
      program_gains(pick_gain(), pick_gain(), pick_gain(), pick_rate());
      if (ph == 2) long_hold = 1'b1;
      for (int i = 0; i < PhaseItems; i++) begin
        if ((ph == 4 && i == PhaseItems / 2) || $urandom_range(0, 149) == 0)
          drain_results();
        pick_sample(sp, ms);
        send_sample(sp, ms);
      end
    end

    drain_results();
    $display("Sent %0d samples under %0d gain settings; %0d drive values checked.",
             n_sent, n_settings, checked);
    $display("Integral clamped %0d times, drive clamped %0d times.",
             integ_clamps, drive_clamps);
    if (pending != 0) $display("%0d drive values never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- pid_controller_step.f -----
hw/rtl/pidc_pkg.sv
hw/rtl/pidc_ctrl.sv
hw/rtl/pidc_datapath.sv
hw/rtl/pid_controller_step.sv
hw/rtl/pidc_checker.sv
dv/pid_drive_checker.sv
dv/testbench.sv
